### hdl/sed_pkg.sv
// Package for the string escape decoder: character constants, result kinds,
// decode modes and the structs passed between the decoder and the result queue.
// No dependencies.
`default_nettype none
package sed_pkg;

   localparam logic [7:0] CHAR_NUL        = 8'h00;
   localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;
   localparam logic [7:0] CHAR_BACKSLASH  = 8'h5C;
   localparam logic [7:0] CHAR_APOSTROPHE = 8'h27;
   localparam logic [7:0] CHAR_DQUOTE     = 8'h22;
   localparam logic [7:0] CHAR_ZERO       = 8'h30;
   localparam logic [7:0] CHAR_SEVEN      = 8'h37;

   localparam logic [2:0] OCT_DIGITS_MAX  = 3'd3;

   localparam logic [1:0] KIND_DATA   = 2'd0;
   localparam logic [1:0] KIND_CLOSED = 2'd1;
   localparam logic [1:0] KIND_BADESC = 2'd2;
   localparam logic [1:0] KIND_UNTERM = 2'd3;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef enum logic [3:0] {
      MODE_IDLE   = 4'b0001,
      MODE_NORMAL = 4'b0010,
      MODE_ESCAPE = 4'b0100,
      MODE_OCTAL  = 4'b1000
   } mode_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] kind;
      logic       octal_overflow;
      logic       last;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type item0;
      rsp_item_type item1;
   } push_type;

endpackage
`default_nettype wire

### hdl/sed_if.sv
// Channel interfaces for the string escape decoder: character beats in,
// result beats out. No dependencies.
`default_nettype none
interface sed_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_char;
   logic       token_start;

   modport source (output valid, output in_char, output token_start, input ready);
   modport sink (input valid, input in_char, input token_start, output ready);
endinterface

interface sed_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [1:0] kind;
   logic       octal_overflow;
   logic       last;

   modport source (output valid, output out_byte, output kind, output octal_overflow,
                   output last, input ready);
   modport sink (input valid, input out_byte, input kind, input octal_overflow,
                 input last, output ready);
endinterface
`default_nettype wire

### hdl/string_escape_decoder_unit.sv
// Top level of the string escape decoder: input register, decoder core and
// result queue. Depends on sed_pkg, sed_if, sed_decode, sed_rsp_queue.
//
// Usage:
//   req_beat carries one character of token data (in_char, token_start).
//   A beat with token_start opens a literal and gives no result; other
//   characters give zero, one or two result beats on rsp_beat, the last
//   of them with last set. Characters outside a literal give no result.
//   csr_write_enable/csr_write_data set quote_is_apostrophe; write it only
//   while no result is outstanding.
// Order: a character is registered on acceptance, decoded from the input
//   register and its result beats are written into the result queue,
//   from which they are shown on rsp_beat.
// Throughput: one character per cycle while the receiver takes results and the queue holds at most two beats;
//   an octal escape ended by a character that also yields a beat gives two
//   beats, read out one per cycle from a four-entry result queue.
// Stall: when the queue holds more than two beats the input register holds
//   and req_beat.ready drops; nothing is lost.
// Reset: synchronous; clears the mode to idle, the octal state, the queue
//   and the quote select (double quote).
`default_nettype none
module string_escape_decoder_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   sed_req_if.sink    req_beat,
   sed_rsp_if.source  rsp_beat,
   input  wire logic  csr_write_enable,
   input  wire logic  csr_write_data
);

   logic       quote_ff;
   logic       stage_valid_ff;
   logic [7:0] stage_char_ff;
   logic       stage_start_ff;
   logic       advance;

   logic [sed_pkg::QUEUE_AW:0] fill;
   sed_pkg::push_type          push;

   assign advance = stage_valid_ff
                    && (fill <= (sed_pkg::QUEUE_AW + 1)'(sed_pkg::QUEUE_DEPTH - 2));
   assign req_beat.ready = !stage_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         quote_ff <= 1'b0;
      end else if (csr_write_enable) begin
         quote_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_beat.ready) begin
         stage_valid_ff <= req_beat.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat.ready && req_beat.valid) begin
         stage_char_ff  <= req_beat.in_char;
         stage_start_ff <= req_beat.token_start;
      end
   end

   sed_decode u_decode (
      .clock               (clock),
      .reset               (reset),
      .advance             (advance),
      .in_char             (stage_char_ff),
      .token_start         (stage_start_ff),
      .quote_is_apostrophe (quote_ff),
      .push                (push)
   );

   sed_rsp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push_en  (advance),
      .push     (push),
      .fill     (fill),
      .rsp_beat (rsp_beat)
   );

endmodule
`default_nettype wire

### hdl/sed_decode.sv
// Escape decoder core: mode, octal accumulator and digit count registers and
// the per-character decode producing up to two result beats. Depends on sed_pkg.
`default_nettype none
module sed_decode (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            advance,
   input  wire logic [7:0]      in_char,
   input  wire logic            token_start,
   input  wire logic            quote_is_apostrophe,
   output sed_pkg::push_type    push
);

   sed_pkg::mode_type mode_ff, mode_in;
   logic [7:0]        accum_ff, accum_in;
   logic [2:0]        count_ff, count_in;

   logic [7:0]        quote;
   logic              is_octal;

   sed_pkg::rsp_item_type norm_item;
   logic                  norm_emit;
   sed_pkg::mode_type     norm_mode;

   assign quote    = quote_is_apostrophe ? sed_pkg::CHAR_APOSTROPHE : sed_pkg::CHAR_DQUOTE;
   assign is_octal = (in_char >= sed_pkg::CHAR_ZERO) && (in_char <= sed_pkg::CHAR_SEVEN);

   always_comb begin
      norm_item = '0;
      norm_emit = 1'b1;
      norm_mode = sed_pkg::MODE_NORMAL;
      priority if (in_char == sed_pkg::CHAR_NUL || in_char == sed_pkg::CHAR_NEWLINE) begin
         norm_item.kind = sed_pkg::KIND_UNTERM;
         norm_mode      = sed_pkg::MODE_IDLE;
      end else if (in_char == sed_pkg::CHAR_BACKSLASH) begin
         norm_emit = 1'b0;
         norm_mode = sed_pkg::MODE_ESCAPE;
      end else if (in_char == quote) begin
         norm_item.kind = sed_pkg::KIND_CLOSED;
         norm_mode      = sed_pkg::MODE_IDLE;
      end else begin
         norm_item.out_byte = in_char;
         norm_item.kind     = sed_pkg::KIND_DATA;
      end
   end

   always_comb begin
      push     = '0;
      mode_in  = mode_ff;
      accum_in = accum_ff;
      count_in = count_ff;
      if (token_start) begin
         mode_in  = sed_pkg::MODE_NORMAL;
         accum_in = '0;
         count_in = '0;
      end else begin
         unique case (mode_ff)
            sed_pkg::MODE_NORMAL: begin
               push.count = {1'b0, norm_emit};
               push.item0 = norm_item;
               mode_in    = norm_mode;
            end
            sed_pkg::MODE_ESCAPE: begin
               push.count = 2'd1;
               push.item0.kind = sed_pkg::KIND_DATA;
               mode_in    = sed_pkg::MODE_NORMAL;
               unique case (in_char)
                  "b": push.item0.out_byte = 8'd8;
                  "a": push.item0.out_byte = 8'd7;
                  "e": push.item0.out_byte = 8'd27;
                  "f": push.item0.out_byte = 8'd12;
                  "n": push.item0.out_byte = 8'd10;
                  "r": push.item0.out_byte = 8'd13;
                  "t": push.item0.out_byte = 8'd9;
                  "v": push.item0.out_byte = 8'd11;
                  default: begin
                     priority if (in_char == sed_pkg::CHAR_NUL) begin
                        push.item0.kind = sed_pkg::KIND_UNTERM;
                        mode_in         = sed_pkg::MODE_IDLE;
                     end else if (is_octal) begin
                        push.count = 2'd0;
                        accum_in   = {5'd0, in_char[2:0]};
                        count_in   = 3'd1;
                        mode_in    = sed_pkg::MODE_OCTAL;
                     end else if (in_char == quote || in_char == sed_pkg::CHAR_BACKSLASH) begin
                        push.item0.out_byte = in_char;
                     end else begin
                        push.item0.kind = sed_pkg::KIND_BADESC;
                        mode_in         = sed_pkg::MODE_IDLE;
                     end
                  end
               endcase
            end
            sed_pkg::MODE_OCTAL: begin
               if (is_octal) begin
                  accum_in = {accum_ff[4:0], in_char[2:0]};
                  if (count_ff <= sed_pkg::OCT_DIGITS_MAX) begin
                     count_in = count_ff + 3'd1;
                  end
               end else begin
                  push.item0.out_byte       = accum_ff;
                  push.item0.kind           = sed_pkg::KIND_DATA;
                  push.item0.octal_overflow = count_ff > sed_pkg::OCT_DIGITS_MAX;
                  push.item1 = norm_item;
                  push.count = norm_emit ? 2'd2 : 2'd1;
                  accum_in   = '0;
                  count_in   = '0;
                  mode_in    = norm_mode;
               end
            end
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end
      if (push.count == 2'd1) begin
         push.item0.last = 1'b1;
      end else if (push.count == 2'd2) begin
         push.item1.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= sed_pkg::MODE_IDLE;
         accum_ff <= '0;
         count_ff <= '0;
      end else if (advance) begin
         mode_ff  <= mode_in;
         accum_ff <= accum_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

### hdl/sed_rsp_queue.sv
// Result queue: takes up to two result beats a cycle from the decoder and
// hands one beat a cycle to the result channel while it is ready. Depends on sed_pkg, sed_if.
`default_nettype none
module sed_rsp_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push_en,
   input  wire sed_pkg::push_type         push,
   output logic [sed_pkg::QUEUE_AW:0]     fill,
   sed_rsp_if.source                      rsp_beat
);

   sed_pkg::rsp_item_type entry_ff [sed_pkg::QUEUE_DEPTH];
   logic [sed_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [sed_pkg::QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [sed_pkg::QUEUE_AW:0]   count_ff, count_in;
   logic [1:0]                   n_push;
   logic                         pop;

   sed_pkg::rsp_item_type head;

   assign n_push = push_en ? push.count : 2'd0;
   assign pop    = rsp_beat.valid && rsp_beat.ready;
   assign fill   = count_ff;

   assign wr_ptr_in = wr_ptr_ff + sed_pkg::QUEUE_AW'(n_push);
   assign rd_ptr_in = rd_ptr_ff + sed_pkg::QUEUE_AW'(pop);
   assign count_in  = count_ff + (sed_pkg::QUEUE_AW + 1)'(n_push)
                      - (sed_pkg::QUEUE_AW + 1)'(pop);

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.item0;
      end
      if (n_push == 2'd2) begin
         entry_ff[wr_ptr_ff + sed_pkg::QUEUE_AW'(1)] <= push.item1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign head                    = entry_ff[rd_ptr_ff];
   assign rsp_beat.valid          = count_ff != '0;
   assign rsp_beat.out_byte       = head.out_byte;
   assign rsp_beat.kind           = head.kind;
   assign rsp_beat.octal_overflow = head.octal_overflow;
   assign rsp_beat.last           = head.last;

endmodule
`default_nettype wire
